FILE: design/spc_pkg.sv
// Shared types and constants for the seam path counter.
package spc_pkg;

    localparam int MAX_COLS  = 256;
    localparam int MAX_ROWS  = 20;

    localparam int ROWS_W    = 8;
    localparam int GCOLS_W   = 9;
    localparam int CELL_W    = 40;
    localparam int COUNT_W   = 39;
    localparam int COLS_W    = $clog2(MAX_COLS + 1);
    localparam int CMP_W     = (COLS_W > GCOLS_W) ? COLS_W : GCOLS_W;
    localparam int ROW_IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ACC_W     = CELL_W + 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_ROWS  = 2'd2
    } t_status;

    // One column count moving down the chain.
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [CELL_W-1:0] data;
    } t_word;

endpackage

FILE: design/seam_path_counter_core.sv
// Top level of the seam path counter: control, column source, cell chain, tap and sum.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one word: grid rows and
//   grid columns. Output channel (o_out_valid / i_out_stall) returns one word
//   per input: the seam count and a status (ok, empty grid, too many rows).
//   A word moves at a rising edge with valid high and stall low.
//   Empty grids and row counts above the limit finish without the chain:
//   the result passes from the finish state into the output register.
//   Otherwise a source streams one column count per cycle (all ones) into a
//   chain of row cells; each cell adds a column's three upper neighbors and
//   passes its row on through its output register. The cell for the last
//   grid row is tapped and summed, and the sum passes from the finish state
//   into the output register (cols saturated to the store depth). The next
//   input word waits until the stream has also left the last cell. The
//   finished result sits in an output register, so the next input word
//   is taken while the receiver stalls; a second result waits until the
//   register frees. Synchronous active-low reset empties the chain and
//   drops any pending result.
module seam_path_counter_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [spc_pkg::ROWS_W-1:0]  i_grid_rows,
    input  logic [spc_pkg::GCOLS_W-1:0] i_grid_cols,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [spc_pkg::COUNT_W-1:0] o_seam_count,
    output logic [1:0]                  o_status
);
    import spc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state             r_state;
    logic [COLS_W-1:0]  r_ncols;
    logic [ROWS_W-1:0]  r_rows;
    logic               r_src_act;
    logic [COLS_W-1:0]  r_src_col;
    logic               r_chain_idle;
    logic [COUNT_W-1:0] r_res_count;
    t_status            r_res_status;
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_count;
    t_status            r_out_status;

    logic               accept;
    logic               is_empty;
    logic               is_rows;
    logic               start;
    logic [CMP_W-1:0]   cols_ext;
    logic [COLS_W-1:0]  n_ncols;
    logic               src_last;
    logic               out_free;
    logic               acc_done;
    logic [COUNT_W-1:0] acc_count;
    logic [ROWS_W-1:0]  tap_sel;
    t_word              tap_word;

    // stage[0] is the first row (all ones); stage[k] is row k
    t_word stage [MAX_ROWS];

    // a new grid starts only once the previous stream has left the last cell,
    // so a deeper tap never picks up its tail
    assign accept   = i_in_valid && (r_state == S_IDLE) && r_chain_idle;
    assign is_empty = (i_grid_rows == '0) || (i_grid_cols == '0);
    assign is_rows  = i_grid_rows > ROWS_W'(MAX_ROWS);
    assign start    = accept && !is_empty && !is_rows;

    assign cols_ext = CMP_W'(i_grid_cols);
    assign n_ncols  = (cols_ext > CMP_W'(MAX_COLS)) ? COLS_W'(MAX_COLS)
                                                     : COLS_W'(cols_ext);

    assign src_last = r_src_col == (r_ncols - COLS_W'(1));
    assign out_free = !r_out_valid || !i_out_stall;

    // column source
    assign stage[0] = {r_src_act, src_last, CELL_W'(1)};

    for (genvar k = 1; k < MAX_ROWS; k++) begin : g_cell
        spc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_word  (stage[k-1]),
            .o_word  (stage[k])
        );
    end

    // tap the cell of the last grid row
    assign tap_sel  = r_rows - ROWS_W'(1);
    assign tap_word = stage[tap_sel[ROW_IDX_W-1:0]];

    spc_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_word  (tap_word),
        .o_done  (acc_done),
        .o_count (acc_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_src_act    <= 1'b0;
            r_src_col    <= '0;
            r_chain_idle <= 1'b1;
            r_out_valid  <= 1'b0;
            r_rows       <= ROWS_W'(1);
        end else begin
            if ((r_state == S_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (start) begin
                r_chain_idle <= 1'b0;
            end else if (stage[MAX_ROWS-1].valid && stage[MAX_ROWS-1].last) begin
                r_chain_idle <= 1'b1;
            end
            if (r_src_act) begin
                r_src_col <= r_src_col + COLS_W'(1);
                if (src_last) begin
                    r_src_act <= 1'b0;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (is_empty) begin
                            r_res_count  <= '0;
                            r_res_status <= ST_EMPTY;
                            r_state      <= S_FIN;
                        end else if (is_rows) begin
                            r_res_count  <= '0;
                            r_res_status <= ST_ROWS;
                            r_state      <= S_FIN;
                        end else begin
                            r_ncols   <= n_ncols;
                            r_rows    <= i_grid_rows;
                            r_src_act <= 1'b1;
                            r_src_col <= '0;
                            r_state   <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (acc_done) begin
                        r_res_count  <= acc_count;
                        r_res_status <= ST_OK;
                        r_state      <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_count  <= r_res_count;
                        r_out_status <= r_res_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE) || !r_chain_idle;
    assign o_out_valid  = r_out_valid;
    assign o_seam_count = r_out_count;
    assign o_status     = r_out_status;

endmodule

FILE: design/spc_cell.sv
// One row cell: turns a stream of counts of the row above into this row's counts.
module spc_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  spc_pkg::t_word i_word,
    output spc_pkg::t_word o_word
);
    import spc_pkg::*;

    logic              r_have;
    logic              r_pend;
    logic [CELL_W-1:0] r_prev;
    logic [CELL_W-1:0] r_cur;
    t_word             r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_pend      <= 1'b0;
            r_out.valid <= 1'b0;
            r_out.last  <= 1'b0;
        end else begin
            r_out.valid <= r_pend || (i_word.valid && r_have);
            r_out.last  <= r_pend;
            if (r_pend) begin
                // last column: no right neighbor
                r_out.data  <= r_prev + r_cur;
                r_pend      <= 1'b0;
                r_have      <= 1'b0;
            end else if (i_word.valid) begin
                if (r_have) begin
                    r_out.data  <= r_prev + r_cur + i_word.data;
                    r_prev      <= r_cur;
                end else begin
                    r_prev <= '0;
                end
                r_cur  <= i_word.data;
                r_have <= 1'b1;
                r_pend <= i_word.last;
            end
        end
    end

    assign o_word = r_out;

endmodule

FILE: design/spc_accum.sv
// Sums the tapped row stream with saturation to the count width.
module spc_accum (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  spc_pkg::t_word               i_word,
    output logic                        o_done,
    output logic [spc_pkg::COUNT_W-1:0] o_count
);
    import spc_pkg::*;

    logic [COUNT_W-1:0] r_acc;
    logic               r_sat;
    logic               r_done;
    logic [ACC_W-1:0]   sum;

    assign sum = ACC_W'(r_acc) + ACC_W'(i_word.data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_sat  <= 1'b0;
            r_acc  <= '0;
        end else begin
            r_done <= !i_start && i_word.valid && i_word.last;
            if (i_start) begin
                r_acc <= '0;
                r_sat <= 1'b0;
            end else if (i_word.valid) begin
                if (sum > ACC_W'(COUNT_MAX)) begin
                    r_sat <= 1'b1;
                end else begin
                    r_acc <= sum[COUNT_W-1:0];
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_count = r_sat ? COUNT_MAX : r_acc;

endmodule

FILE: tb/tb_seam_path_counter_core.sv
// Self-checking testbench for the seam path counter: directed table, random grids, backpressure.
module tb_seam_path_counter_core;
    import spc_pkg::*;

    localparam int DIR_N       = 22;
    localparam int RAND_N      = 88;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN       = 2 * (MAX_COLS + MAX_ROWS) + 10;
    localparam int IDLE_LIMIT  = 5000;

    typedef struct {
        logic [ROWS_W-1:0]  rows;
        logic [GCOLS_W-1:0] cols;
        logic [COUNT_W-1:0] count;
        t_status            status;
    } t_seam_result;

    // one directed row; known == 1 means count/status are typed in here
    typedef struct packed {
        logic [ROWS_W-1:0]  rows;
        logic [GCOLS_W-1:0] cols;
        logic               known;
        logic [COUNT_W-1:0] count;
        t_status            status;
    } t_grid_case;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [ROWS_W-1:0]   i_grid_rows;
    logic [GCOLS_W-1:0]  i_grid_cols;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [COUNT_W-1:0]  o_seam_count;
    logic [1:0]          o_status;

    t_seam_result pending_seams[$];
    t_grid_case   grid_cases[DIR_N];
    int           mismatches = 0;
    int           idle_cycles = 0;
    bit           hold_off = 1'b0;
    bit           no_gaps = 1'b0;
    int           burst_left = 0;

    seam_path_counter_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_grid_rows  (i_grid_rows),
        .i_grid_cols  (i_grid_cols),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_seam_count (o_seam_count),
        .o_status     (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Path counts row by row over a 40-bit row store, then summed and clamped to 39 bits.
    function automatic t_seam_result count_seams(logic [ROWS_W-1:0] rows,
                                                 logic [GCOLS_W-1:0] cols);
        logic [CELL_W-1:0] paths [MAX_COLS];
        logic [CELL_W-1:0] left, here, right;
        logic [63:0]       total;
        int                ncols, r, j;
        t_seam_result      res;
        res.rows   = rows;
        res.cols   = cols;
        res.count  = '0;
        res.status = ST_OK;
        if (rows == 0 || cols == 0) begin
            res.status = ST_EMPTY;
        end else if (rows > MAX_ROWS) begin
            res.status = ST_ROWS;
        end else begin
            ncols = (cols > MAX_COLS) ? MAX_COLS : int'(cols);
            for (j = 0; j < ncols; j++) paths[j] = CELL_W'(1);
            for (r = 1; r < int'(rows); r++) begin
                left = '0;
                for (j = 0; j < ncols; j++) begin
                    here     = paths[j];
                    right    = (j + 1 < ncols) ? paths[j + 1] : '0;
                    paths[j] = left + here + right;
                    left     = here;
                end
            end
            total = '0;
            for (j = 0; j < ncols; j++) total += 64'(paths[j]);
            if (total > 64'(COUNT_MAX)) total = 64'(COUNT_MAX);
            res.count = total[COUNT_W-1:0];
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (no_gaps || burst_left > 0) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(30, 120);
    endfunction

    // Offer one word, hold it until taken, then queue what it should produce.
    task automatic send_grid(logic [ROWS_W-1:0] rows, logic [GCOLS_W-1:0] cols,
                             bit known, logic [COUNT_W-1:0] count, t_status status);
        int           gap;
        t_seam_result res;
        gap = pick_gap();
        if (burst_left > 0) burst_left--;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_grid_rows <= rows;
        i_grid_cols <= cols;
        do @(posedge i_clk); while (o_in_stall);
        if (known) begin
            res.rows   = rows;
            res.cols   = cols;
            res.count  = count;
            res.status = status;
        end else begin
            res = count_seams(rows, cols);
        end
        pending_seams = {pending_seams, res};
    endtask

    // Receiver: random stall stretches, a long hold-off on request, quiet phases.
    initial begin : receiver
        int stall_left;
        int roll;
        stall_left  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off = 1'b0;
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
            end else if (no_gaps) begin
                i_out_stall <= 1'b0;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 65) begin
                    i_out_stall <= 1'b0;
                end else if (roll < 93) begin
                    i_out_stall <= 1'b1;
                    stall_left = $urandom_range(0, 3);
                end else begin
                    i_out_stall <= 1'b1;
                    stall_left = $urandom_range(20, 80);
                end
            end
        end
    end

    // Result check against the oldest queued expectation.
    always @(posedge i_clk) begin
        t_seam_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_seams.size() == 0) begin
                $display("%0t: unexpected result count=%0d status=%0d",
                         $time, o_seam_count, o_status);
                mismatches++;
            end else begin
                want = pending_seams.pop_front();
                if (o_seam_count !== want.count) begin
                    $display("%0t: seam_count rows=%0d cols=%0d expected %0d actual %0d",
                             $time, want.rows, want.cols, want.count, o_seam_count);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status rows=%0d cols=%0d expected %0d actual %0d",
                             $time, want.rows, want.cols, want.status, o_status);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles with no word moving on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("%0t: watchdog, no progress", $time);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [ROWS_W-1:0]  rows;
        logic [GCOLS_W-1:0] cols;
        int                 roll;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_grid_rows = '0;
        i_grid_cols = '0;

        grid_cases = '{
            '{8'd0,   9'd0,   1'b1, 39'd0,   ST_EMPTY},
            '{8'd0,   9'd5,   1'b1, 39'd0,   ST_EMPTY},
            '{8'd5,   9'd0,   1'b1, 39'd0,   ST_EMPTY},
            '{8'd255, 9'd0,   1'b1, 39'd0,   ST_EMPTY},   // empty wins over row limit
            '{8'd0,   9'd511, 1'b1, 39'd0,   ST_EMPTY},
            '{8'd21,  9'd10,  1'b1, 39'd0,   ST_ROWS},
            '{8'd128, 9'd1,   1'b1, 39'd0,   ST_ROWS},
            '{8'd255, 9'd511, 1'b1, 39'd0,   ST_ROWS},
            '{8'd1,   9'd1,   1'b1, 39'd1,   ST_OK},
            '{8'd1,   9'd256, 1'b1, 39'd256, ST_OK},      // single row: count = cols
            '{8'd1,   9'd511, 1'b1, 39'd256, ST_OK},      // cols clamp to store depth
            '{8'd20,  9'd1,   1'b1, 39'd1,   ST_OK},
            '{8'd2,   9'd2,   1'b1, 39'd4,   ST_OK},
            '{8'd20,  9'd256, 1'b0, 39'd0,   ST_OK},      // largest count
            '{8'd20,  9'd511, 1'b0, 39'd0,   ST_OK},
            '{8'd20,  9'd2,   1'b0, 39'd0,   ST_OK},
            '{8'd3,   9'd3,   1'b0, 39'd0,   ST_OK},
            '{8'd20,  9'd255, 1'b0, 39'd0,   ST_OK},
            '{8'd10,  9'd300, 1'b0, 39'd0,   ST_OK},
            '{8'd7,   9'd257, 1'b0, 39'd0,   ST_OK},
            '{8'd19,  9'd170, 1'b0, 39'd0,   ST_OK},
            '{8'd20,  9'd85,  1'b0, 39'd0,   ST_OK}
        };

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIR_N; k++) begin
            send_grid(grid_cases[k].rows, grid_cases[k].cols, grid_cases[k].known,
                      grid_cases[k].count, grid_cases[k].status);
        end

        for (int k = 0; k < RAND_N; k++) begin
            if (k == 25) begin
                // receiver parks for a long stretch while words keep coming
                hold_off   = 1'b1;
                burst_left = 8;
            end
            if (k == 50) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                wait (pending_seams.size() == 0);
            end
            if (k == 65) no_gaps = 1'b1;
            if (k == 78) no_gaps = 1'b0;
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                rows = 8'($urandom_range(1, MAX_ROWS));
                roll = $urandom_range(0, 99);
                if (roll < 85) cols = 9'($urandom_range(1, 16));
                else if (roll < 95) cols = 9'($urandom_range(17, MAX_COLS));
                else cols = 9'($urandom_range(MAX_COLS + 1, 511));
            end else if (roll < 90) begin
                rows = 8'($urandom_range(MAX_ROWS + 1, 255));
                cols = 9'($urandom_range(0, 511));
            end else begin
                rows = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
                cols = (rows == 0) ? 9'($urandom_range(0, 511)) : 9'd0;
            end
            send_grid(rows, cols, 1'b0, '0, ST_OK);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (pending_seams.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/spc_pkg.sv
design/spc_cell.sv
design/spc_accum.sv
design/seam_path_counter_core.sv
tb/tb_seam_path_counter_core.sv
